[rtl/core/bpfr_pkg.sv]
// Shared constants, codes and types of the byte pattern find and replace block.
`default_nettype none
package bpfr_pkg;

    localparam int PATTERN_MAX  = 64;
    localparam int REPLACE_MAX  = 256;
    localparam int WINDOW_DEPTH = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 8;
    localparam int PLEN_W   = 7;
    localparam int RLEN_W   = 9;
    localparam int HITS_W   = 16;
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W    = (CNT_W > RLEN_W) ? CNT_W : RLEN_W;
    localparam int PAT_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [ACTION_W-1:0] ACT_LOAD_PAT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_REP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DATA     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FLUSH    = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_REPLACE_LENGTH = 1'b1;

    typedef struct packed {
        logic [PLEN_W-1:0] pattern_length;
        logic [RLEN_W-1:0] replace_length;
    } t_cfg;

    typedef struct packed {
        logic              insert;
        logic              emit;
        logic              load_rep;
        logic              patch;
        logic [BYTE_W-1:0] value;
        logic [CNT_W-1:0]  slot;
        logic [CNT_W-1:0]  held;
        logic [CNT_W-1:0]  p;
        logic [CNT_W-1:0]  patch_len;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/core/bpfr_if.sv]
// Valid/ready channel interfaces for input items and result words.
`default_nettype none
interface bpfr_in_if import bpfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;
    logic [BYTE_W-1:0]   byte_value;

    modport source (output valid, output action, output slot_index, output byte_value,
                    input ready);
    modport sink   (input valid, input action, input slot_index, input byte_value,
                    output ready);
endinterface

interface bpfr_out_if import bpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              patched_here;
    logic [HITS_W-1:0] match_count;
    logic              drained;

    modport source (output valid, output out_byte, output patched_here, output match_count,
                    output drained, input ready);
    modport sink   (input valid, input out_byte, input patched_here, input match_count,
                    input drained, output ready);
endinterface
`default_nettype wire

[rtl/core/bpfr_cfg.sv]
// APB register file holding the pattern and replacement lengths.
`default_nettype none
module bpfr_cfg import bpfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [PLEN_W-1:0]    r_pattern_length;
    logic [RLEN_W-1:0]    r_replace_length;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PLEN_W'(1);
            r_replace_length <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[PLEN_W-1:0];
                REG_REPLACE_LENGTH: r_replace_length <= pwdata[RLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(r_pattern_length);
            REG_REPLACE_LENGTH: prdata = APB_DATA_W'(r_replace_length);
            default: prdata = '0;
        endcase
    end

    assign o_cfg.pattern_length = r_pattern_length;
    assign o_cfg.replace_length = r_replace_length;

endmodule
`default_nettype wire

[rtl/core/bpfr_cell.sv]
// One window cell: a held byte, its replacement byte, compare and patch logic.
`default_nettype none
module bpfr_cell import bpfr_pkg::*; (
    input  logic              i_clk,
    input  logic [CNT_W-1:0]  i_index,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic [BYTE_W-1:0] i_next,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_eq
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] n_win;
    logic [BYTE_W-1:0] r_rep;
    logic [BYTE_W-1:0] cur;
    logic              ins;
    logic              patch;

    assign ins    = i_ctl.insert && (i_index == i_ctl.held);
    assign cur    = ins ? i_ctl.value : r_win;
    assign o_eq   = (i_index >= i_ctl.p) || (cur == i_pat);
    assign patch  = i_ctl.patch && (i_index < i_ctl.patch_len);
    assign o_byte = patch ? r_rep : cur;

    always_comb begin
        n_win = r_win;
        if (i_ctl.emit) begin
            n_win = i_next;
        end else if (ins) begin
            n_win = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_ctl.load_rep && (i_ctl.slot == i_index)) begin
            r_rep <= i_ctl.value;
        end
    end

endmodule
`default_nettype wire

[rtl/core/byte_pattern_find_replace.sv]
// Top level of the streaming byte pattern find and replace block.
//
// Input words on i_item carry an action: load a pattern byte, load a
// replacement byte, push a stream byte, or flush one held byte. Loads give
// no result. Stream bytes collect in a row of window cells until the window
// holds max(pattern_length, replace_length) bytes; from then on each stream
// byte pushes out the oldest one. Flush words drain the held bytes one by one.
// Before a byte leaves, all pattern positions are compared in parallel across
// the cells; on a hit the replacement is written over the window in place.
// Result words on o_result carry the byte, the hit flag, the saturating hit
// count and the drained flag.
// Throughput: one word per cycle while i_item.ready is high; the compare and
// shift across the cell row are combinational. The result of an accepted
// word is captured in the output register. While that register is full and
// the receiver holds ready low, i_item.ready is low. Reset clears the held
// count, the hit count, the output valid flag and the lengths (pattern 1,
// replacement 0); pattern and replacement stores are undefined until loaded.
// Lengths must be written over APB only while idle; the block does not check.
`default_nettype none
module byte_pattern_find_replace import bpfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpfr_in_if.sink               i_item,
    bpfr_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg              cfg;
    t_cell_ctl         ctl;
    logic [BYTE_W-1:0] r_pat [PATTERN_MAX];
    logic [BYTE_W-1:0] cell_byte [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] cell_eq;

    logic [CNT_W-1:0]  r_held;
    logic [CNT_W-1:0]  n_held;
    logic [HITS_W-1:0] r_hits;
    logic [HITS_W-1:0] n_hits;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_patched;
    logic [HITS_W-1:0] r_out_count;
    logic              r_out_drained;

    logic              fire;
    logic              is_load_pat;
    logic              is_load_rep;
    logic              is_data;
    logic              is_flush;
    logic              emit;
    logic              match;
    logic [CMP_W-1:0]  p_wide;
    logic [CMP_W-1:0]  r_wide;
    logic [CNT_W-1:0]  p_eff;
    logic [CNT_W-1:0]  r_eff;
    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  avail;

    bpfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign fire         = i_item.valid && i_item.ready;

    always_comb begin
        is_load_pat = 1'b0;
        is_load_rep = 1'b0;
        is_data     = 1'b0;
        is_flush    = 1'b0;
        unique case (i_item.action)
            ACT_LOAD_PAT: is_load_pat = 1'b1;
            ACT_LOAD_REP: is_load_rep = 1'b1;
            ACT_DATA:     is_data     = 1'b1;
            ACT_FLUSH:    is_flush    = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        p_wide = CMP_W'(cfg.pattern_length);
        if (p_wide == '0) begin
            p_wide = CMP_W'(1);
        end else if (p_wide > CMP_W'(PATTERN_MAX)) begin
            p_wide = CMP_W'(PATTERN_MAX);
        end
        r_wide = CMP_W'(cfg.replace_length);
        if (r_wide > CMP_W'(REPLACE_MAX)) begin
            r_wide = CMP_W'(REPLACE_MAX);
        end
    end

    assign p_eff = p_wide[CNT_W-1:0];
    assign r_eff = r_wide[CNT_W-1:0];
    assign w_eff = (p_eff > r_eff) ? p_eff : r_eff;
    assign avail = is_data ? (r_held + CNT_W'(1)) : r_held;

    assign emit  = fire && ((is_data && (avail >= w_eff)) || (is_flush && (r_held != '0)));
    assign match = emit && (p_eff <= avail) && (&cell_eq[PATTERN_MAX-1:0]);

    always_comb begin
        ctl.insert    = fire && is_data;
        ctl.emit      = emit;
        ctl.load_rep  = fire && is_load_rep;
        ctl.patch     = match;
        ctl.value     = i_item.byte_value;
        ctl.slot      = CNT_W'(i_item.slot_index);
        ctl.held      = r_held;
        ctl.p         = p_eff;
        ctl.patch_len = (r_eff < avail) ? r_eff : avail;
    end

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        logic [BYTE_W-1:0] pat_k;
        logic [BYTE_W-1:0] next_k;
        if (k < PATTERN_MAX) begin : g_pat
            assign pat_k = r_pat[k];
        end else begin : g_nopat
            assign pat_k = '0;
        end
        if (k < WINDOW_DEPTH - 1) begin : g_mid
            assign next_k = cell_byte[k+1];
        end else begin : g_last
            assign next_k = '0;
        end
        bpfr_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CNT_W'(k)),
            .i_ctl   (ctl),
            .i_pat   (pat_k),
            .i_next  (next_k),
            .o_byte  (cell_byte[k]),
            .o_eq    (cell_eq[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_load_pat && (CMP_W'(i_item.slot_index) < CMP_W'(PATTERN_MAX))) begin
            r_pat[i_item.slot_index[PAT_IDX_W-1:0]] <= i_item.byte_value;
        end
    end

    always_comb begin
        n_held = r_held;
        if (fire && is_data && !emit) begin
            n_held = r_held + CNT_W'(1);
        end else if (fire && is_flush && emit) begin
            n_held = r_held - CNT_W'(1);
        end
        n_hits = r_hits;
        if (match && (r_hits != '1)) begin
            n_hits = r_hits + HITS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            r_hits <= n_hits;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte    <= cell_byte[0];
            r_out_patched <= match;
            r_out_count   <= n_hits;
            r_out_drained <= is_flush && (r_held == CNT_W'(1));
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_byte     = r_out_byte;
    assign o_result.patched_here = r_out_patched;
    assign o_result.match_count  = r_out_count;
    assign o_result.drained      = r_out_drained;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < CNT_W'(WINDOW_DEPTH))
        else $error("held count reached window depth");

    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("emitted byte not registered");

    a_data_emit_keeps_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_data && emit) |=> $stable(r_held))
        else $error("held count moved on a pass-through byte");

    a_patch_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_patched) |-> (r_out_count != '0))
        else $error("hit reported with zero count");

    a_drained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_drained) |-> (r_held == '0))
        else $error("drained reported with bytes still held");

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for byte_pattern_find_replace: random and directed words, self-checking predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpfr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int ITEM_TARGET = 1850;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot_index;
        logic [BYTE_W-1:0]   byte_value;
    } t_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              patched_here;
        logic [HITS_W-1:0] match_count;
        logic              drained;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    bpfr_in_if  item_if ();
    bpfr_out_if res_if ();

    byte_pattern_find_replace u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // pending words and expected result words
    t_word   word_q[$];
    t_result expected_q[$];

    // predictor state
    logic [BYTE_W-1:0] win_mem [WINDOW_DEPTH];
    logic [BYTE_W-1:0] pat_mem [PATTERN_MAX];
    logic [BYTE_W-1:0] rep_mem [REPLACE_MAX];
    int unsigned       win_head = 0;
    int unsigned       win_held = 0;
    logic [HITS_W-1:0] hit_total = '0;
    logic [PLEN_W-1:0] plen_reg = PLEN_W'(1);
    logic [RLEN_W-1:0] rlen_reg = '0;

    // generator state
    logic [BYTE_W-1:0] gen_pat [PATTERN_MAX];
    int unsigned gen_plen = 1;
    int unsigned gen_rlen = 0;
    int unsigned gen_held = 0;
    int unsigned items_sent = 0;
    int unsigned items_taken = 0;
    int unsigned items_counted = 0;

    int snd_idle_pct = 21;
    int rcv_idle_pct = 50;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    bit word_taken = 1'b0;
    int quiet_cycles = 0;
    int err_count = 0;

    function automatic int unsigned clamp_plen(int unsigned v);
        if (v < 1) return 1;
        if (v > PATTERN_MAX) return PATTERN_MAX;
        return v;
    endfunction

    function automatic int unsigned clamp_rlen(int unsigned v);
        if (v > REPLACE_MAX) return REPLACE_MAX;
        return v;
    endfunction

    function automatic int unsigned gen_width();
        return (gen_plen > gen_rlen) ? gen_plen : gen_rlen;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_symbol();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h5A;
            3: return 8'hA5;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // check the oldest byte against the pattern, patch it, emit and drop it
    function automatic void emit_oldest_byte(bit on_flush);
        int unsigned p;
        int unsigned r;
        int unsigned n;
        bit hit;
        t_result res;
        p = clamp_plen(32'(plen_reg));
        r = clamp_rlen(32'(rlen_reg));
        hit = (p <= win_held);
        for (int unsigned k = 0; k < p && hit; k++) begin
            if (win_mem[(win_head + k) % WINDOW_DEPTH] != pat_mem[k]) hit = 1'b0;
        end
        if (hit) begin
            n = (r < win_held) ? r : win_held;
            for (int unsigned k = 0; k < n; k++) win_mem[(win_head + k) % WINDOW_DEPTH] = rep_mem[k];
            if (hit_total != {HITS_W{1'b1}}) hit_total++;
        end
        res.out_byte = win_mem[win_head];
        res.patched_here = hit;
        res.match_count = hit_total;
        win_head = (win_head + 1) % WINDOW_DEPTH;
        win_held--;
        res.drained = on_flush && (win_held == 0);
        expected_q.push_back(res);
    endfunction

    function automatic void predict_word(t_word w);
        int unsigned wlen;
        wlen = clamp_plen(32'(plen_reg));
        if (clamp_rlen(32'(rlen_reg)) > wlen) wlen = clamp_rlen(32'(rlen_reg));
        case (w.action)
            ACT_LOAD_PAT: begin
                if (w.slot_index < PATTERN_MAX)
                    pat_mem[w.slot_index[PAT_IDX_W-1:0]] = w.byte_value;
            end
            ACT_LOAD_REP: begin
                if (w.slot_index < REPLACE_MAX) rep_mem[w.slot_index] = w.byte_value;
            end
            ACT_DATA: begin
                win_mem[(win_head + win_held) % WINDOW_DEPTH] = w.byte_value;
                win_held++;
                if (win_held >= wlen) emit_oldest_byte(1'b0);
            end
            ACT_FLUSH: begin
                if (win_held != 0) emit_oldest_byte(1'b1);
            end
        endcase
    endfunction

    task automatic push_word(logic [ACTION_W-1:0] action, int unsigned slot,
                             logic [BYTE_W-1:0] value);
        t_word w;
        w.action = action;
        w.slot_index = SLOT_W'(slot);
        w.byte_value = value;
        word_q.push_back(w);
        items_sent++;
        case (action)
            ACT_LOAD_PAT: begin
                if (slot < PATTERN_MAX) begin
                    gen_pat[slot] = value;
                    items_counted++;
                end
            end
            ACT_LOAD_REP: items_counted++;
            ACT_DATA: begin
                items_counted++;
                gen_held++;
                if (gen_held >= gen_width()) gen_held--;
            end
            ACT_FLUSH: begin
                if (gen_held != 0) begin
                    gen_held--;
                    items_counted++;
                end
            end
        endcase
    endtask

    task automatic apb_access(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_PATTERN_LENGTH) plen_reg = value[PLEN_W-1:0];
        else rlen_reg = value[RLEN_W-1:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = (idx == REG_PATTERN_LENGTH) ? APB_DATA_W'(plen_reg) : APB_DATA_W'(rlen_reg);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every word is taken and every result seen, then let the block settle
    task automatic settle();
        @(negedge i_clk);
        while (items_taken != items_sent || expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_lengths(int unsigned plen_raw, int unsigned rlen_raw);
        settle();
        apb_access(REG_PATTERN_LENGTH, APB_DATA_W'(plen_raw));
        apb_access(REG_REPLACE_LENGTH, APB_DATA_W'(rlen_raw));
        gen_plen = clamp_plen(plen_raw);
        gen_rlen = clamp_rlen(rlen_raw);
    endtask

    task automatic run_phase(int idx);
        int unsigned plen_raw;
        int unsigned rlen_raw;
        int unsigned n_data;
        int unsigned sel;
        int unsigned n;
        int unsigned k;
        logic [BYTE_W-1:0] v;
        case (idx)
            0: begin plen_raw = 1; rlen_raw = 0; end
            1: begin plen_raw = 64; rlen_raw = 256; end
            2: begin plen_raw = 127; rlen_raw = 0; end
            3: begin plen_raw = 0; rlen_raw = 511; end
            default: begin
                sel = $urandom_range(0, 99);
                if (sel < 70) plen_raw = $urandom_range(1, 6);
                else if (sel < 80) plen_raw = 0;
                else if (sel < 95) plen_raw = $urandom_range(7, 20);
                else plen_raw = $urandom_range(21, 127);
                sel = $urandom_range(0, 99);
                if (sel < 60) rlen_raw = $urandom_range(0, 8);
                else if (sel < 85) rlen_raw = $urandom_range(9, 24);
                else rlen_raw = 0;
            end
        endcase
        set_lengths(plen_raw, rlen_raw);

        for (k = 0; k < gen_plen; k++) push_word(ACT_LOAD_PAT, k, pick_symbol());
        n = (gen_rlen < 16) ? gen_rlen : 16;
        for (k = 0; k < n; k++) push_word(ACT_LOAD_REP, k, pick_symbol());

        case (idx)
            1: n_data = gen_width() + 20;
            2: n_data = 40;
            3: n_data = 30;
            default: n_data = gen_width() + $urandom_range(5, 40);
        endcase
        k = 0;
        while (k < n_data) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                for (int unsigned m = 0; m < gen_plen; m++) begin
                    v = gen_pat[m];
                    if (sel < 8 && m == gen_plen - 1) v = ~v;
                    push_word(ACT_DATA, 0, v);
                end
                k += gen_plen;
            end else if (sel < 40 && idx >= 4) begin
                push_word(ACT_FLUSH, $urandom_range(0, 255), BYTE_W'($urandom));
            end else if (sel < 43) begin
                push_word(($urandom_range(0, 1) != 0) ? ACT_LOAD_PAT : ACT_LOAD_REP,
                          $urandom_range(0, 255), BYTE_W'($urandom));
            end else begin
                if ($urandom_range(0, 9) < 7) v = gen_pat[$urandom_range(0, gen_plen - 1)];
                else v = BYTE_W'($urandom);
                push_word(ACT_DATA, $urandom_range(0, 255), v);
                k++;
            end
        end

        if (idx == 5) begin
            @(posedge i_clk);
            hold_asked++;
        end

        if (idx != 1) begin
            if (idx < 4 || $urandom_range(0, 3) != 0) n = gen_held + $urandom_range(0, 2);
            else n = $urandom_range(0, gen_held);
            repeat (n) push_word(ACT_FLUSH, $urandom_range(0, 255), BYTE_W'($urandom));
        end
    endtask

    // driver: offer pending words
    always @(negedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || word_taken) begin
            if (word_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                w = word_q.pop_front();
                item_if.valid <= 1'b1;
                item_if.action <= w.action;
                item_if.slot_index <= w.slot_index;
                item_if.byte_value <= w.byte_value;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (hold_done != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asked;
        end
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // monitor: check results, predict accepted words, watch for a stall
    always @(posedge i_clk) begin
        t_result want;
        bit res_fire;
        res_fire = 1'b0;
        word_taken = 1'b0;
        if (i_rst_n) begin
            res_fire = res_if.valid && res_if.ready;
            if (res_fire) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(res_if.out_byte), '0);
                end else begin
                    want = expected_q.pop_front();
                    if (res_if.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 32'(res_if.out_byte),
                                        32'(want.out_byte));
                    if (res_if.patched_here !== want.patched_here)
                        report_mismatch("patched_here", 32'(res_if.patched_here),
                                        32'(want.patched_here));
                    if (res_if.match_count !== want.match_count)
                        report_mismatch("match_count", 32'(res_if.match_count),
                                        32'(want.match_count));
                    if (res_if.drained !== want.drained)
                        report_mismatch("drained", 32'(res_if.drained), 32'(want.drained));
                end
            end
            word_taken = item_if.valid && item_if.ready;
            if (word_taken) begin
                predict_word({item_if.action, item_if.slot_index, item_if.byte_value});
                items_taken++;
            end
            if (word_taken || res_fire) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] dir_stream [12];
        int phase;
        int n;
        dir_stream = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                       8'h00, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h00};
        item_if.valid = 1'b0;
        item_if.action = ACT_LOAD_PAT;
        item_if.slot_index = '0;
        item_if.byte_value = '0;
        res_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_lengths(3, 5);
        push_word(ACT_FLUSH, 0, 8'h00);
        for (int k = 0; k < PATTERN_MAX; k++) push_word(ACT_LOAD_PAT, k, BYTE_W'($urandom));
        for (int k = 0; k < REPLACE_MAX; k++) push_word(ACT_LOAD_REP, k, BYTE_W'($urandom));
        push_word(ACT_LOAD_PAT, 0, 8'h00);
        push_word(ACT_LOAD_PAT, 1, 8'hFF);
        push_word(ACT_LOAD_PAT, 2, 8'h00);
        push_word(ACT_LOAD_PAT, PATTERN_MAX, 8'h11);
        push_word(ACT_LOAD_PAT, 255, 8'hEE);
        push_word(ACT_LOAD_REP, 0, 8'hFF);
        push_word(ACT_LOAD_REP, 1, 8'h00);
        push_word(ACT_LOAD_REP, 2, 8'hFF);
        push_word(ACT_LOAD_REP, 3, 8'h81);
        push_word(ACT_LOAD_REP, 4, 8'h7E);
        push_word(ACT_LOAD_REP, 255, 8'h3C);
        for (int k = 0; k < 12; k++) push_word(ACT_DATA, 255, dir_stream[k]);
        repeat (5) push_word(ACT_FLUSH, 255, 8'hFF);

        phase = 0;
        while (items_counted < ITEM_TARGET) begin
            if (items_counted < ITEM_TARGET / 3) begin
                snd_idle_pct = 21;
                rcv_idle_pct = 50;
            end else if (items_counted < 2 * ITEM_TARGET / 3) begin
                snd_idle_pct = 50;
                rcv_idle_pct = 21;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            run_phase(phase);
            phase++;
        end

        @(negedge i_clk);
        while (items_taken != items_sent) @(negedge i_clk);
        n = 0;
        while (expected_q.size() != 0 && n < 500) begin
            @(negedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_q.size() != 0) report_mismatch("results never seen", expected_q.size(), 0);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/bpfr_pkg.sv
rtl/core/bpfr_if.sv
rtl/core/bpfr_cfg.sv
rtl/core/bpfr_cell.sv
rtl/core/byte_pattern_find_replace.sv
test/tb.sv
